FILE: src/sfsc_pkg.sv
// ----------------------------------------------------------------------------
// sfsc_pkg
// Shared types, codes and constants of the two-scale weighing controller.
// ----------------------------------------------------------------------------
package sfsc_pkg;

  // fixed field widths
  localparam int WEIGHT_W    = 16;
  localparam int LIMIT_W     = 7;
  localparam int THRESH_W    = 8;
  localparam int STEP_W      = 5;
  localparam int KEY_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int QUIET_W     = 2;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 56;

  // stability window defaults
  localparam int WINDOW_LIMIT_DEF = 20;
  localparam logic [QUIET_W-1:0] QUIET_WINDOWS = 2'd3;

  // limit clamps and reset values
  localparam logic [LIMIT_W-1:0] LIMIT_MIN = 7'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 7'd100;
  localparam logic [LIMIT_W-1:0] LIMIT_GAP = 7'd5;
  localparam logic [THRESH_W-1:0] THRESH_RST = 8'd5;
  localparam logic [STEP_W-1:0]   STEP_RST   = 5'd5;

  // key codes
  localparam logic [KEY_W-1:0] KEY_NONE    = 4'd0;
  localparam logic [KEY_W-1:0] KEY_BEGIN   = 4'd1;
  localparam logic [KEY_W-1:0] KEY_ADVANCE = 4'd2;
  localparam logic [KEY_W-1:0] KEY_RETURN  = 4'd3;
  localparam logic [KEY_W-1:0] KEY_ABORT   = 4'd4;
  localparam logic [KEY_W-1:0] KEY_MENU    = 4'd5;
  localparam logic [KEY_W-1:0] KEY_LOW_DN  = 4'd6;
  localparam logic [KEY_W-1:0] KEY_LOW_UP  = 4'd7;
  localparam logic [KEY_W-1:0] KEY_HIGH_DN = 4'd8;
  localparam logic [KEY_W-1:0] KEY_HIGH_UP = 4'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_INIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_INIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd3;

  // request kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_KEY  = 1'b1;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_WEIGH   = 2'd1,
    MODE_DONE    = 2'd2
  } mode_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] lower;
    logic [LIMIT_W-1:0] upper;
  } bounds_t;

  function automatic logic [LIMIT_W-1:0] clamp_limit(input logic [LIMIT_W-1:0] v);
    logic [LIMIT_W-1:0] r;
    r = v;
    if (v < LIMIT_MIN) r = LIMIT_MIN;
    if (v > LIMIT_MAX) r = LIMIT_MAX;
    return r;
  endfunction

endpackage

FILE: src/sfsc_limits.sv
// ----------------------------------------------------------------------------
// sfsc_limits
// Limit key handling: steps the lower and upper bounds with their clamps.
// ----------------------------------------------------------------------------
module sfsc_limits
  import sfsc_pkg::*;
(
  input  logic              en,
  input  logic [KEY_W-1:0]  key,
  input  logic [STEP_W-1:0] step,
  input  bounds_t           cur,
  output bounds_t           nxt
);

  logic [LIMIT_W:0] lo8;
  logic [LIMIT_W:0] up8;
  logic [LIMIT_W:0] st8;
  logic [LIMIT_W:0] low_sum;
  logic [LIMIT_W:0] low_floor;
  logic [LIMIT_W:0] high_sum;
  logic [LIMIT_W:0] high_gap;
  logic [LIMIT_W:0] high_gap_step;
  logic [LIMIT_W:0] high_dec;

  // widened operands so sums cannot wrap
  assign lo8           = {1'b0, cur.lower};
  assign up8           = {1'b0, cur.upper};
  assign st8           = {{(LIMIT_W+1-STEP_W){1'b0}}, step};
  assign low_sum       = lo8 + st8;
  assign low_floor     = {1'b0, LIMIT_MIN} + st8;
  assign high_sum      = up8 + st8;
  assign high_gap      = lo8 + {1'b0, LIMIT_GAP};
  assign high_gap_step = high_gap + st8;
  assign high_dec      = (up8 < high_gap_step) ? high_gap : (up8 - st8);

  // bound update per key
  always_comb begin
    nxt = cur;
    if (en) begin
      case (key)
        KEY_LOW_DN: begin
          nxt.lower = (lo8 < low_floor) ? LIMIT_MIN : (cur.lower - LIMIT_W'(step));
        end
        KEY_LOW_UP: begin
          nxt.lower = (low_sum > up8) ? cur.upper : low_sum[LIMIT_W-1:0];
        end
        KEY_HIGH_DN: begin
          nxt.upper = (high_dec > {1'b0, LIMIT_MAX}) ? LIMIT_MAX : high_dec[LIMIT_W-1:0];
        end
        KEY_HIGH_UP: begin
          nxt.upper = (high_sum > {1'b0, LIMIT_MAX}) ? LIMIT_MAX : high_sum[LIMIT_W-1:0];
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

FILE: src/scale_fill_stability_controller_unit.sv
// ----------------------------------------------------------------------------
// scale_fill_stability_controller_unit
// Two-scale weighing controller: tare, net weights, stability windows,
// limit keys and the standby / weighing / done mode.
// ----------------------------------------------------------------------------
// path: each item passes the input register, then the result register, to m_axis
// throughput: one item per cycle unless m_axis stalls; input and result registers
//   are the only stages; state updates as an item leaves stage one, if cfg_we is low
// reset: rst is synchronous; mode standby, tares, nets, counters and barcode flag
//   cleared, stable flag set, limits 10 and 100, threshold 5, step 5
module scale_fill_stability_controller_unit
  import sfsc_pkg::*;
#(
  parameter int WINDOW_LIMIT = WINDOW_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // key_code, raw_first_weight,
                                               // raw_second_weight, barcode_seen
  input  logic                  s_axis_tuser,  // req_type
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // status, net_first, net_second,
                                               // low_limit, high_limit, is_stable
);

  localparam int WT_W = $clog2(WINDOW_LIMIT + 2);
  localparam logic [WT_W-1:0] WT_LAST = WT_W'(WINDOW_LIMIT);

  // input register
  logic                s1_valid;
  logic                s1_req;
  logic [KEY_W-1:0]    s1_key;
  logic [WEIGHT_W-1:0] s1_raw1;
  logic [WEIGHT_W-1:0] s1_raw2;
  logic                s1_seen;
  logic                advance;

  // controller state
  mode_t               mode;
  mode_t               mode_next;
  logic [WEIGHT_W-1:0] tare1;
  logic [WEIGHT_W-1:0] tare2;
  logic [WEIGHT_W-1:0] tare1_next;
  logic [WEIGHT_W-1:0] tare2_next;
  logic [WEIGHT_W-1:0] net1;
  logic [WEIGHT_W-1:0] net2;
  logic [WEIGHT_W-1:0] net1_next;
  logic [WEIGHT_W-1:0] net2_next;
  bounds_t             bounds;
  bounds_t             bounds_next;
  logic [WEIGHT_W-1:0] prev_raw;
  logic [WEIGHT_W-1:0] prev_raw_next;
  logic [WT_W-1:0]     window_ticks;
  logic [WT_W-1:0]     window_ticks_next;
  logic [QUIET_W-1:0]  quiet_run;
  logic [QUIET_W-1:0]  quiet_run_next;
  logic [QUIET_W-1:0]  quiet_inc;
  logic                stable;
  logic                stable_next;
  logic                barcode;
  logic                barcode_next;
  logic [THRESH_W-1:0] threshold;
  logic [STEP_W-1:0]   step;

  // datapath helpers
  logic [WEIGHT_W-1:0] diff;
  logic                net1_in_lim;
  logic                limit_key;

  // result register
  logic [OUT_DATA_W-1:0] out_data;

  assign advance       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      s1_req  <= s_axis_tuser;
      s1_key  <= s_axis_tdata[3:0];
      s1_raw1 <= s_axis_tdata[19:4];
      s1_raw2 <= s_axis_tdata[35:20];
      s1_seen <= s_axis_tdata[36];
    end
  end

  // limit keys
  assign limit_key = advance && (s1_req == REQ_KEY);

  sfsc_limits u_limits (
    .en   (limit_key),
    .key  (s1_key),
    .step (step),
    .cur  (bounds),
    .nxt  (bounds_next)
  );

  // net weights and stability window helpers
  assign diff        = (prev_raw > s1_raw1) ? (prev_raw - s1_raw1) : (s1_raw1 - prev_raw);
  assign quiet_inc   = quiet_run + 2'd1;
  assign net1_in_lim = ({{(WEIGHT_W-LIMIT_W){1'b0}}, bounds.lower} <= net1_next) &&
                       (net1_next <= {{(WEIGHT_W-LIMIT_W){1'b0}}, bounds.upper});

  // next state of the controller for the item in stage one
  always_comb begin
    mode_next         = mode;
    tare1_next        = tare1;
    tare2_next        = tare2;
    net1_next         = net1;
    net2_next         = net2;
    prev_raw_next     = prev_raw;
    window_ticks_next = window_ticks;
    quiet_run_next    = quiet_run;
    stable_next       = stable;
    barcode_next      = barcode;
    if (s1_req == REQ_KEY) begin
      case (s1_key)
        KEY_BEGIN, KEY_ADVANCE: begin
          tare1_next   = s1_raw1;
          tare2_next   = s1_raw2;
          barcode_next = 1'b0;
          mode_next    = MODE_WEIGH;
        end
        KEY_RETURN, KEY_ABORT: begin
          mode_next = MODE_STANDBY;
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end else begin
      if (s1_seen) barcode_next = 1'b1;
      net1_next = (s1_raw1 > tare1) ? (s1_raw1 - tare1) : '0;
      net2_next = (s1_raw2 > tare2) ? (s1_raw2 - tare2) : '0;
      // stability window
      if (window_ticks > WT_LAST) begin
        window_ticks_next = '0;
        if (net1_in_lim) begin
          if (diff < {{(WEIGHT_W-THRESH_W){1'b0}}, threshold}) begin
            if (quiet_inc < QUIET_WINDOWS) begin
              quiet_run_next = quiet_inc;
              stable_next    = 1'b0;
            end else begin
              quiet_run_next = '0;
              stable_next    = 1'b1;
            end
          end else begin
            quiet_run_next = '0;
            stable_next    = 1'b0;
          end
          prev_raw_next = s1_raw1;
        end else begin
          stable_next = 1'b0;
        end
      end else begin
        window_ticks_next = window_ticks + WT_W'(1);
      end
      // finish test
      if ((mode == MODE_WEIGH) && net1_in_lim && stable_next && barcode_next) begin
        mode_next = MODE_DONE;
      end
    end
  end

  // state registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_STANDBY;
      tare1        <= '0;
      tare2        <= '0;
      net1         <= '0;
      net2         <= '0;
      bounds.lower <= LIMIT_MIN;
      bounds.upper <= LIMIT_MAX;
      prev_raw     <= '0;
      window_ticks <= '0;
      quiet_run    <= '0;
      stable       <= 1'b1;
      barcode      <= 1'b0;
      threshold    <= THRESH_RST;
      step         <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOW_INIT:  bounds.lower <= clamp_limit(cfg_data[LIMIT_W-1:0]);
        CFG_HIGH_INIT: bounds.upper <= clamp_limit(cfg_data[LIMIT_W-1:0]);
        CFG_THRESH:    threshold    <= cfg_data[THRESH_W-1:0];
        CFG_STEP:      step         <= cfg_data[STEP_W-1:0];
        default:       step         <= step;
      endcase
    end else if (advance) begin
      mode         <= mode_next;
      tare1        <= tare1_next;
      tare2        <= tare2_next;
      net1         <= net1_next;
      net2         <= net2_next;
      bounds       <= bounds_next;
      prev_raw     <= prev_raw_next;
      window_ticks <= window_ticks_next;
      quiet_run    <= quiet_run_next;
      stable       <= stable_next;
      barcode      <= barcode_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (advance) begin
      out_data <= {7'd0, stable_next, bounds_next.upper, bounds_next.lower,
                   net2_next, net1_next, mode_next};
    end
  end

  assign m_axis_tdata = out_data;

  // checks
  a_quiet_range: assert property (@(posedge clk) disable iff (rst)
    quiet_run < QUIET_WINDOWS)
    else $error("quiet run count reached the window count");

  a_window_range: assert property (@(posedge clk) disable iff (rst)
    window_ticks <= WT_W'(WINDOW_LIMIT + 1))
    else $error("window tick counter past its wrap point");

  a_bounds_range: assert property (@(posedge clk) disable iff (rst)
    bounds.lower >= LIMIT_MIN && bounds.lower <= LIMIT_MAX &&
    bounds.upper >= LIMIT_MIN && bounds.upper <= LIMIT_MAX)
    else $error("limit bound outside 10..100");

  a_done_from_weigh: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_DONE && $past(mode) != MODE_DONE) |-> $past(mode) == MODE_WEIGH)
    else $error("done entered from a mode other than weighing");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    (!s1_valid && !cfg_we) |=> $stable(mode) && $stable(window_ticks))
    else $error("controller state moved with no item in stage one");

endmodule
